// ===== rtl/core/rwdh_pkg.sv =====
// ----------------------------------------------------------------------------
// rwdh_pkg
// Shared constants, codes and types of the readout word decode histogrammer.
// ----------------------------------------------------------------------------
package rwdh_pkg;

  localparam int VALUE_BINS          = 4096;
  localparam int CHANNELS_PER_MODULE = 64;
  localparam int MODULES             = 2;
  localparam int COUNT_BITS          = 32;

  localparam int KINDS       = 4;
  localparam int TOTAL_CH    = MODULES * CHANNELS_PER_MODULE;
  localparam int STORE_DEPTH = KINDS * TOTAL_CH * VALUE_BINS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [31:0] FRAME_MASK  = 32'h8080_8080;
  localparam logic [31:0] FRAME_RESET = 32'h8000_0000;

  typedef enum logic {
    OP_PARSE = 1'b0,
    OP_READ  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_HDR0      = 3'd0,
    ST_HDR1      = 3'd1,
    ST_FILLED    = 3'd2,
    ST_OTR       = 3'd3,
    ST_UNCLASS   = 3'd4,
    ST_FRAME_ERR = 3'd5,
    ST_READ      = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    K_ADC_HIGH  = 2'd0,
    K_ADC_LOW   = 2'd1,
    K_TDC_LEAD  = 2'd2,
    K_TDC_TRAIL = 2'd3
  } kind_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [31:0] raw_word;
    logic [1:0]  read_kind;
    logic [6:0]  read_channel;
    logic [11:0] read_bin;
  } in_req_t;

  typedef struct packed {
    status_e     status;
    logic [27:0] decoded_word;
    kind_e       kind;
    logic [6:0]  channel;
    logic [11:0] value;
    logic [31:0] bin_count;
  } res_t;

  typedef struct packed {
    logic              rd_en;
    logic              inc;
    logic [ADDR_W-1:0] addr;
    res_t              res;
  } hist_req_t;

endpackage

// ===== rtl/core/rwdh_intf.sv =====
// ----------------------------------------------------------------------------
// rwdh_intf
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface rwdh_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [31:0] raw_word;
  logic [1:0]  read_kind;
  logic [6:0]  read_channel;
  logic [11:0] read_bin;

  modport source (output valid, opcode, raw_word, read_kind, read_channel, read_bin,
                  input ready);
  modport sink (input valid, opcode, raw_word, read_kind, read_channel, read_bin,
                output ready);
endinterface

interface rwdh_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [27:0] decoded_word;
  logic [1:0]  kind;
  logic [6:0]  channel;
  logic [11:0] value;
  logic [31:0] bin_count;

  modport source (output valid, status, decoded_word, kind, channel, value, bin_count,
                  input ready);
  modport sink (input valid, status, decoded_word, kind, channel, value, bin_count,
                output ready);
endinterface

interface rwdh_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== rtl/core/rwdh_decode.sv =====
// ----------------------------------------------------------------------------
// rwdh_decode
// Frame check, word packing, stream parser and classification into store
// addresses.
// ----------------------------------------------------------------------------
module rwdh_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  rwdh_pkg::in_req_t   req_i,
  input  logic [31:0]         frame_pattern_i,
  output rwdh_pkg::hist_req_t hreq_o
);
  import rwdh_pkg::*;

  typedef enum logic [1:0] {
    PH_HDR0  = 2'd0,
    PH_DATA0 = 2'd1,
    PH_HDR1  = 2'd2,
    PH_DATA1 = 2'd3
  } phase_e;

  localparam logic [6:0]  CPM_L   = 7'(CHANNELS_PER_MODULE);
  localparam logic [7:0]  TOTCH_L = 8'(TOTAL_CH);
  localparam logic [12:0] BINS_L  = 13'(VALUE_BINS);

  phase_e      phase_q, phase_d, end_phase;
  logic [11:0] words_left_q, words_left_d;

  logic        frame_ok;
  logic [27:0] packed_w, dw;
  logic [5:0]  rawch;
  logic [11:0] val;
  logic        otr, is_adc, classified, in_range, rd_ok, module_one;
  kind_e       kind;
  logic [6:0]  ch;

  function automatic logic [ADDR_W-1:0] store_addr(logic [1:0] k, logic [6:0] c,
                                                   logic [11:0] b);
    store_addr = ADDR_W'(k) * ADDR_W'(TOTAL_CH * VALUE_BINS)
               + ADDR_W'(c) * ADDR_W'(VALUE_BINS) + ADDR_W'(b);
  endfunction

  always_comb begin
    frame_ok   = (req_i.raw_word & FRAME_MASK) == (frame_pattern_i & FRAME_MASK);
    packed_w   = {req_i.raw_word[30:24], req_i.raw_word[22:16],
                  req_i.raw_word[14:8], req_i.raw_word[6:0]};
    dw         = frame_ok ? packed_w : '0;
    rawch      = dw[18:13];
    val        = dw[11:0];
    otr        = dw[12];
    module_one = (phase_q == PH_DATA1);

    is_adc     = 1'b0;
    classified = 1'b1;
    kind       = K_ADC_HIGH;
    priority if ({dw[22], dw[21], dw[19]} == 3'b000) begin
      kind   = K_ADC_HIGH;
      is_adc = 1'b1;
    end else if ({dw[22], dw[21], dw[19]} == 3'b001) begin
      kind   = K_ADC_LOW;
      is_adc = 1'b1;
    end else if ({dw[22], dw[21], dw[12]} == 3'b011) begin
      kind = K_TDC_LEAD;
    end else if ({dw[22], dw[21], dw[12]} == 3'b010) begin
      kind = K_TDC_TRAIL;
    end else begin
      classified = 1'b0;
    end

    in_range = ({1'b0, rawch} < CPM_L) && ({1'b0, val} < BINS_L);
    ch       = 7'(rawch) + (module_one ? CPM_L : 7'd0);

    if (((phase_q == PH_HDR0) || (phase_q == PH_DATA0)) && (MODULES >= 2)) begin
      end_phase = PH_HDR1;
    end else begin
      end_phase = PH_HDR0;
    end

    rd_ok        = ({1'b0, req_i.read_channel} < TOTCH_L)
                && ({1'b0, req_i.read_bin} < BINS_L);
    hreq_o       = '0;
    phase_d      = phase_q;
    words_left_d = words_left_q;

    unique case (req_i.opcode)
      OP_READ: begin
        hreq_o.rd_en       = rd_ok;
        hreq_o.addr        = store_addr(req_i.read_kind, req_i.read_channel,
                                        req_i.read_bin);
        hreq_o.res.status  = ST_READ;
        hreq_o.res.kind    = kind_e'(req_i.read_kind);
        hreq_o.res.channel = req_i.read_channel;
        hreq_o.res.value   = req_i.read_bin;
      end
      OP_PARSE: begin
        unique case (phase_q)
          PH_HDR0, PH_HDR1: begin
            if (!frame_ok) begin
              hreq_o.res.status = ST_FRAME_ERR;
            end else if (phase_q == PH_HDR0) begin
              hreq_o.res.status = ST_HDR0;
            end else begin
              hreq_o.res.status = ST_HDR1;
            end
            hreq_o.res.decoded_word = dw;
            hreq_o.res.value        = dw[11:0];
            words_left_d            = dw[11:0];
            if (dw[11:0] == 12'd0) begin
              phase_d = end_phase;
            end else if (phase_q == PH_HDR0) begin
              phase_d = PH_DATA0;
            end else begin
              phase_d = PH_DATA1;
            end
          end
          PH_DATA0, PH_DATA1: begin
            words_left_d = words_left_q - 12'd1;
            if (words_left_d == 12'd0) begin
              phase_d = end_phase;
            end
            priority if (!frame_ok) begin
              hreq_o.res.status = ST_FRAME_ERR;
            end else if (!classified || !in_range) begin
              hreq_o.res.status       = ST_UNCLASS;
              hreq_o.res.decoded_word = dw;
            end else if (is_adc && otr) begin
              hreq_o.res.status       = ST_OTR;
              hreq_o.res.decoded_word = dw;
              hreq_o.res.kind         = kind;
              hreq_o.res.channel      = ch;
              hreq_o.res.value        = val;
            end else begin
              hreq_o.rd_en            = 1'b1;
              hreq_o.inc              = 1'b1;
              hreq_o.addr             = store_addr(kind, ch, val);
              hreq_o.res.status       = ST_FILLED;
              hreq_o.res.decoded_word = dw;
              hreq_o.res.kind         = kind;
              hreq_o.res.channel      = ch;
              hreq_o.res.value        = val;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HDR0;
      words_left_q <= '0;
    end else if (accept_i && (req_i.opcode == OP_PARSE)) begin
      phase_q      <= phase_d;
      words_left_q <= words_left_d;
    end
  end

endmodule

// ===== rtl/core/rwdh_hist.sv =====
// ----------------------------------------------------------------------------
// rwdh_hist
// Histogram store with clearing sweep, read-modify-write stage and write
// forwarding for back-to-back hits on one bin.
// ----------------------------------------------------------------------------
module rwdh_hist (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  rwdh_pkg::hist_req_t hreq_i,
  input  logic                advance_i,
  output logic                s1_valid_o,
  output rwdh_pkg::res_t      res_o,
  output logic                busy_o
);
  import rwdh_pkg::*;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  logic [COUNT_BITS-1:0] mem [STORE_DEPTH];

  logic                  clr_busy_q;
  logic [ADDR_W-1:0]     clr_addr_q;
  logic                  s1_valid_q;
  hist_req_t             s1_q;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  fwd_valid_q;
  logic [ADDR_W-1:0]     fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;

  logic                  upd_en, wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] wr_data, cur_count, new_count;

  always_comb begin
    cur_count = (fwd_valid_q && (fwd_addr_q == s1_q.addr)) ? fwd_data_q : rd_q;
    new_count = (cur_count == COUNT_MAX) ? cur_count : cur_count + 1'b1;
    upd_en    = s1_valid_q && advance_i && s1_q.inc;
    wr_en     = clr_busy_q || upd_en;
    wr_addr   = clr_busy_q ? clr_addr_q : s1_q.addr;
    wr_data   = clr_busy_q ? '0 : new_count;

    res_o = s1_q.res;
    if (s1_q.rd_en) begin
      res_o.bin_count = 32'(s1_q.inc ? new_count : cur_count);
    end
  end

  // store access
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (accept_i && hreq_i.rd_en) begin
      rd_q <= mem[hreq_i.addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        if (clr_addr_q == LAST_ADDR) begin
          clr_busy_q <= 1'b0;
        end else begin
          clr_addr_q <= clr_addr_q + 1'b1;
        end
      end
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (advance_i) begin
        s1_valid_q <= 1'b0;
      end
      if (upd_en) begin
        fwd_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= hreq_i;
    end
    if (upd_en) begin
      fwd_addr_q <= s1_q.addr;
      fwd_data_q <= new_count;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign busy_o     = clr_busy_q;

endmodule

// ===== rtl/core/readout_word_decode_histogrammer_unit.sv =====
// ----------------------------------------------------------------------------
// readout_word_decode_histogrammer_unit
// Readout word decoder with histogram store, bin read-back and frame check.
// Path: store read stage, then output register. Throughput: one request
// per cycle unless a result stall or the clearing sweep holds requests off,
// set by the single store read port and the read-modify-write with write
// forwarding. Reset: parser returns to the module-0 header, frame pattern
// to 0x80000000; the store is then swept to zero over all 2,097,152 words
// with requests held off; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module readout_word_decode_histogrammer_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  rwdh_in_if.sink    req_if,
  rwdh_out_if.source res_if,
  rwdh_cfg_if.sink   cfg_if
);
  import rwdh_pkg::*;

  logic [31:0] frame_pattern_q;
  logic        out_valid_q;
  res_t        out_q;

  in_req_t   req;
  hist_req_t hreq;
  res_t      s1_res;
  logic      s1_valid, busy, advance, accept;

  assign req.opcode       = opcode_e'(req_if.opcode);
  assign req.raw_word     = req_if.raw_word;
  assign req.read_kind    = req_if.read_kind;
  assign req.read_channel = req_if.read_channel;
  assign req.read_bin     = req_if.read_bin;

  assign advance      = !out_valid_q || res_if.ready;
  assign req_if.ready = !busy && (!s1_valid || advance);
  assign accept       = req_if.valid && req_if.ready;
  assign cfg_if.ready = 1'b1;

  rwdh_decode u_decode (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .req_i           (req),
    .frame_pattern_i (frame_pattern_q),
    .hreq_o          (hreq)
  );

  rwdh_hist u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .hreq_i     (hreq),
    .advance_i  (advance),
    .s1_valid_o (s1_valid),
    .res_o      (s1_res),
    .busy_o     (busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_pattern_q <= FRAME_RESET;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        frame_pattern_q <= cfg_if.data;
      end
      if (s1_valid && advance) begin
        out_valid_q <= 1'b1;
      end else if (res_if.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid && advance) begin
      out_q <= s1_res;
    end
  end

  assign res_if.valid        = out_valid_q;
  assign res_if.status       = out_q.status;
  assign res_if.decoded_word = out_q.decoded_word;
  assign res_if.kind         = out_q.kind;
  assign res_if.channel      = out_q.channel;
  assign res_if.value        = out_q.value;
  assign res_if.bin_count    = out_q.bin_count;

endmodule

// ===== test/rwdh_result_checker.sv =====
// ----------------------------------------------------------------------------
// rwdh_result_checker
// Watches the request, result and configuration channels of the readout word
// decode histogrammer. It keeps its own parser state, frame pattern and
// histogram, works out the result of every accepted request and compares
// each accepted result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module rwdh_result_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rwdh_in_if   req_if,
  rwdh_out_if  res_if,
  rwdh_cfg_if  cfg_if,
  output int   errors_o,
  output int   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rwdh_pkg::*;

  typedef enum logic [1:0] {
    PH_HDR0  = 2'd0,
    PH_DATA0 = 2'd1,
    PH_HDR1  = 2'd2,
    PH_DATA1 = 2'd3
  } parse_phase_e;

  localparam logic [27:0] KIND_MASK      = 28'h068_0000;
  localparam logic [27:0] ADC_LOW_BITS   = 28'h008_0000;
  localparam logic [27:0] TDC_MASK       = 28'h060_1000;
  localparam logic [27:0] TDC_LEAD_BITS  = 28'h020_1000;
  localparam logic [27:0] TDC_TRAIL_BITS = 28'h020_0000;
  localparam logic [31:0] COUNT_MAX      = 32'hFFFF_FFFF >> (32 - COUNT_BITS);

  logic [31:0]  frame_pat;
  parse_phase_e phase;
  logic [11:0]  words_left;
  logic [31:0]  hist [int unsigned];
  res_t         expected_q [$];
  int           fail_count = 0;

  assign errors_o = fail_count;

  function automatic int unsigned bin_index(logic [1:0] k, logic [6:0] ch, logic [11:0] v);
    return (int'(k) * TOTAL_CH + int'(ch)) * VALUE_BINS + int'(v);
  endfunction

  function automatic void close_module();
    if ((phase == PH_HDR0 || phase == PH_DATA0) && MODULES >= 2) begin
      phase = PH_HDR1;
    end else begin
      phase = PH_HDR0;
    end
  endfunction

  function automatic res_t decode_and_count(input in_req_t r);
    res_t         o;
    logic         ok;
    logic         mod1;
    logic         adc;
    logic [27:0]  d;
    logic [5:0]   rch;
    logic [6:0]   ch;
    logic [31:0]  c;
    kind_e        k;
    int unsigned  idx;
    o = '0;
    if (r.opcode == OP_READ) begin
      o.status  = ST_READ;
      o.kind    = kind_e'(r.read_kind);
      o.channel = r.read_channel;
      o.value   = r.read_bin;
      if (int'(r.read_channel) < TOTAL_CH && int'(r.read_bin) < VALUE_BINS) begin
        idx = bin_index(r.read_kind, r.read_channel, r.read_bin);
        if (hist.exists(idx)) begin
          o.bin_count = hist[idx];
        end
      end
      return o;
    end

    ok = ((r.raw_word ^ frame_pat) & FRAME_MASK) == '0;
    d  = ok ? {r.raw_word[30:24], r.raw_word[22:16], r.raw_word[14:8], r.raw_word[6:0]}
            : '0;

    // header: a broken one counts as an empty module
    if (phase == PH_HDR0 || phase == PH_HDR1) begin
      if (ok) begin
        o.status       = (phase == PH_HDR0) ? ST_HDR0 : ST_HDR1;
        o.decoded_word = d;
        o.value        = d[11:0];
      end else begin
        o.status = ST_FRAME_ERR;
      end
      words_left = d[11:0];
      if (words_left == '0) begin
        close_module();
      end else begin
        phase = parse_phase_e'(phase + 2'd1);
      end
      return o;
    end

    // data word uses up one of the count whatever it holds
    mod1       = (phase == PH_DATA1);
    words_left = words_left - 12'd1;
    if (words_left == '0) begin
      close_module();
    end
    if (!ok) begin
      o.status = ST_FRAME_ERR;
      return o;
    end

    o.status       = ST_UNCLASS;
    o.decoded_word = d;
    rch            = d[18:13];
    if ((d & KIND_MASK) == '0) begin
      k   = K_ADC_HIGH;
      adc = 1'b1;
    end else if ((d & KIND_MASK) == ADC_LOW_BITS) begin
      k   = K_ADC_LOW;
      adc = 1'b1;
    end else if ((d & TDC_MASK) == TDC_LEAD_BITS) begin
      k   = K_TDC_LEAD;
      adc = 1'b0;
    end else if ((d & TDC_MASK) == TDC_TRAIL_BITS) begin
      k   = K_TDC_TRAIL;
      adc = 1'b0;
    end else begin
      return o;
    end
    if (int'(rch) >= CHANNELS_PER_MODULE || int'(d[11:0]) >= VALUE_BINS) begin
      return o;
    end

    ch        = 7'(rch) + (mod1 ? 7'(CHANNELS_PER_MODULE) : 7'd0);
    o.kind    = k;
    o.channel = ch;
    o.value   = d[11:0];
    if (adc && d[12]) begin
      o.status = ST_OTR;
      return o;
    end
    idx = bin_index(k, ch, d[11:0]);
    c   = hist.exists(idx) ? hist[idx] : '0;
    if (c < COUNT_MAX) begin
      c = c + 32'd1;
    end
    hist[idx]   = c;
    o.status    = ST_FILLED;
    o.bin_count = c;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_req_t r;
    res_t    got;
    res_t    want;
    if (!rst_ni) begin
      frame_pat  = FRAME_RESET;
      phase      = PH_HDR0;
      words_left = '0;
      hist.delete();
      expected_q.delete();
      pending_o  = 0;
    end else begin
      if (cfg_if.valid && cfg_if.ready) begin
        frame_pat = cfg_if.data;
      end
      if (req_if.valid && req_if.ready) begin
        r.opcode       = opcode_e'(req_if.opcode);
        r.raw_word     = req_if.raw_word;
        r.read_kind    = req_if.read_kind;
        r.read_channel = req_if.read_channel;
        r.read_bin     = req_if.read_bin;
        expected_q.push_back(decode_and_count(r));
      end
      if (res_if.valid && res_if.ready) begin
        got.status       = status_e'(res_if.status);
        got.decoded_word = res_if.decoded_word;
        got.kind         = kind_e'(res_if.kind);
        got.channel      = res_if.channel;
        got.value        = res_if.value;
        got.bin_count    = res_if.bin_count;
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with none outstanding, expected nothing, got st=%0d dw=%07h",
                   $time, got.status, got.decoded_word,
                   " k=%0d ch=%0d v=%0d cnt=%0d",
                   got.kind, got.channel, got.value, got.bin_count);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count++;
            $display("%0t: result mismatch, expected st=%0d dw=%07h k=%0d ch=%0d v=%0d",
                     $time, want.status, want.decoded_word, want.kind, want.channel,
                     want.value, " cnt=%0d, got st=%0d dw=%07h k=%0d ch=%0d v=%0d cnt=%0d",
                     want.bin_count, got.status, got.decoded_word, got.kind, got.channel,
                     got.value, got.bin_count);
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== test/tb_readout_word_decode_histogrammer_unit.sv =====
// ----------------------------------------------------------------------------
// tb_readout_word_decode_histogrammer_unit
// Drives readout word streams and bin reads into the histogrammer: a short
// directed run over the special cases, then framed module events with random
// content, broken framing and random words, under several frame patterns and
// random idling on both channels. The checker instance does the comparison.
// ----------------------------------------------------------------------------
module tb_readout_word_decode_histogrammer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rwdh_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [31:0] frame_bits;
  int          gap_pct;
  int          stall_pct;
  int          n_items;
  int          errors;
  int          pending;

  rwdh_in_if  req_if ();
  rwdh_out_if res_if ();
  rwdh_cfg_if cfg_if ();

  readout_word_decode_histogrammer_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_if (req_if),
    .res_if (res_if),
    .cfg_if (cfg_if)
  );

  rwdh_result_checker i_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_if    (req_if),
    .res_if    (res_if),
    .cfg_if    (cfg_if),
    .errors_o  (errors),
    .pending_o (pending)
  );

  always #5ns clk_i = ~clk_i;

  initial begin
    #80ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [31:0] with_frame(logic [27:0] d);
    return {frame_bits[31], d[27:21], frame_bits[23], d[20:14],
            frame_bits[15], d[13:7], frame_bits[7], d[6:0]};
  endfunction

  function automatic logic [31:0] frame_flip();
    logic [31:0] f;
    f = 32'h80 << (8 * $urandom_range(0, 3));
    return f | ($urandom & FRAME_MASK);
  endfunction

  function automatic logic [27:0] make_data(kind_e k, logic unc, logic [5:0] ch,
                                            logic [11:0] v, logic otr);
    logic [27:0] d;
    d        = 28'($urandom);
    d[11:0]  = v;
    d[12]    = otr;
    d[18:13] = ch;
    d[22]    = unc;
    if (!unc) begin
      case (k)
        K_ADC_HIGH: begin
          d[21] = 1'b0;
          d[19] = 1'b0;
        end
        K_ADC_LOW: begin
          d[21] = 1'b0;
          d[19] = 1'b1;
        end
        K_TDC_LEAD: begin
          d[21] = 1'b1;
          d[12] = 1'b1;
        end
        default: begin
          d[21] = 1'b1;
          d[12] = 1'b0;
        end
      endcase
    end
    return d;
  endfunction

  task automatic push_req(input in_req_t r);
    logic acc;
    if ($urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.opcode       <= r.opcode;
    req_if.raw_word     <= r.raw_word;
    req_if.read_kind    <= r.read_kind;
    req_if.read_channel <= r.read_channel;
    req_if.read_bin     <= r.read_bin;
    do begin
      @(negedge clk_i);
      acc = req_if.ready;
      @(posedge clk_i);
    end while (!acc);
    n_items++;
  endtask

  task automatic send_word(input logic [31:0] raw);
    in_req_t r;
    r.opcode       = OP_PARSE;
    r.raw_word     = raw;
    r.read_kind    = 2'($urandom);
    r.read_channel = 7'($urandom);
    r.read_bin     = 12'($urandom);
    push_req(r);
  endtask

  task automatic send_read(input logic [1:0] k, input logic [6:0] ch, input logic [11:0] b);
    in_req_t r;
    r.opcode       = OP_READ;
    r.raw_word     = $urandom;
    r.read_kind    = k;
    r.read_channel = ch;
    r.read_bin     = b;
    push_req(r);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  task automatic write_pattern(input logic [31:0] pat);
    logic acc;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= pat;
    do begin
      @(negedge clk_i);
      acc = cfg_if.ready;
      @(posedge clk_i);
    end while (!acc);
    cfg_if.valid <= 1'b0;
    frame_bits = pat;
  endtask

  // bins half of the time from a small corner so that reads find counts
  task automatic maybe_read();
    logic [6:0]  ch;
    logic [11:0] b;
    if ($urandom_range(0, 99) < 15) begin
      if ($urandom_range(0, 1) == 0) begin
        ch = 7'($urandom_range(0, 3) + 64 * $urandom_range(0, 1));
        b  = 12'($urandom_range(0, 3));
      end else begin
        ch = 7'($urandom);
        b  = 12'($urandom);
      end
      send_read(2'($urandom), ch, b);
    end
  endtask

  task automatic send_data_word();
    int          sel;
    logic [5:0]  ch;
    logic [11:0] v;
    sel = $urandom_range(0, 99);
    ch  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 3));
    v   = ($urandom_range(0, 3) == 0) ? 12'($urandom) : 12'($urandom_range(0, 3));
    if (sel < 6) begin
      send_word($urandom);
    end else if (sel < 12) begin
      send_word(with_frame(28'($urandom)) ^ frame_flip());
    end else begin
      send_word(with_frame(make_data(kind_e'($urandom_range(0, 3)), sel < 20, ch, v,
                                     $urandom_range(0, 5) == 0)));
    end
  endtask

  task automatic send_event();
    int n;
    if ($urandom_range(0, 49) == 0) begin
      wait_drained();
    end
    for (int m = 0; m < MODULES; m++) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      maybe_read();
      if ($urandom_range(0, 19) == 0) begin
        send_word(with_frame({16'($urandom), 12'(n)}) ^ frame_flip());
        n = 0;
      end else begin
        send_word(with_frame({16'($urandom), 12'(n)}));
      end
      for (int i = 0; i < n; i++) begin
        maybe_read();
        send_data_word();
      end
    end
  endtask

  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  initial begin
    logic [31:0] pats [6];
    int          wait_cnt;
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.opcode       <= OP_PARSE;
    req_if.raw_word     <= '0;
    req_if.read_kind    <= '0;
    req_if.read_channel <= '0;
    req_if.read_bin     <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.data         <= '0;
    frame_bits = FRAME_RESET;
    gap_pct    = 20;
    stall_pct  = 20;
    n_items    = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_pattern(32'h8000_0000);

    // directed: empty store read, every kind, edges, broken framing, empty module
    send_read(K_TDC_TRAIL, 7'd127, 12'd4095);
    send_word(with_frame({16'h0000, 12'd8}));
    send_word(with_frame(make_data(K_ADC_HIGH, 1'b0, 6'd0, 12'd0, 1'b0)));
    send_word(with_frame(make_data(K_ADC_HIGH, 1'b0, 6'd0, 12'd0, 1'b0)));
    send_word(with_frame(make_data(K_ADC_LOW, 1'b0, 6'd63, 12'd4095, 1'b0)));
    send_word(with_frame(make_data(K_ADC_HIGH, 1'b0, 6'd5, 12'd100, 1'b1)));
    send_word(with_frame(make_data(K_TDC_LEAD, 1'b0, 6'd1, 12'd4095, 1'b0)));
    send_word(with_frame(make_data(K_TDC_TRAIL, 1'b0, 6'd63, 12'd0, 1'b0)));
    send_word(with_frame(make_data(K_ADC_HIGH, 1'b1, 6'd2, 12'd3, 1'b0)));
    send_word(with_frame(make_data(K_ADC_LOW, 1'b0, 6'd1, 12'd1, 1'b0)) ^ FRAME_MASK);
    send_word(with_frame({16'hFFFF, 12'd5}) ^ 32'h8000_0000);
    send_word(with_frame('0));
    send_word(with_frame({16'h0000, 12'd3}));
    send_word(with_frame(make_data(K_ADC_HIGH, 1'b0, 6'd0, 12'd0, 1'b0)));
    send_word(with_frame(make_data(K_TDC_LEAD, 1'b0, 6'd63, 12'd4095, 1'b0)));
    send_read(K_ADC_HIGH, 7'd0, 12'd0);
    send_word(with_frame(make_data(K_ADC_LOW, 1'b0, 6'd10, 12'd7, 1'b1)));
    send_read(K_ADC_HIGH, 7'd64, 12'd0);
    send_read(K_TDC_LEAD, 7'd127, 12'd4095);
    send_read(K_ADC_LOW, 7'd63, 12'd4095);
    send_word(with_frame({16'hFFFF, 12'd1}));
    send_word(32'hFFFF_FFFF);
    send_word(with_frame({16'h0000, 12'd1}));
    send_word(32'h0000_0000);

    pats = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8080_8080, 32'h0080_0080,
             32'h0, 32'h8000_0000};
    pats[4] = $urandom;
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      write_pattern(pats[p]);
      gap_pct   = (p == 2) ? 0 : $urandom_range(5, 40);
      stall_pct = (p == 3) ? 0 : $urandom_range(5, 40);
      while (n_items < 25 + 250 * (p + 1)) send_event();
    end

    // closing stretch at full rate
    gap_pct   = 0;
    stall_pct = 0;
    while (n_items < 1700) send_event();
    req_if.valid <= 1'b0;

    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 2000) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (8) @(negedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/rwdh_pkg.sv
rtl/core/rwdh_intf.sv
rtl/core/rwdh_decode.sv
rtl/core/rwdh_hist.sv
rtl/core/readout_word_decode_histogrammer_unit.sv
test/rwdh_result_checker.sv
test/tb_readout_word_decode_histogrammer_unit.sv
